[rtl/bru_pkg.sv]
// shared types, command codes and widths for the branch resolution unit
`timescale 1ns / 1ps

package bru_pkg;

	localparam int ADDR_BITS = 32;
	localparam int REG_BITS  = 64;
	localparam int CMD_BITS  = 3;

	localparam logic [CMD_BITS-1:0] CMD_BX     = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_BC     = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_BCCTR  = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_BCLR   = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_WCOUNT = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_WLINK  = 3'd5;

	typedef struct packed {
		logic [CMD_BITS-1:0]  command;
		logic [ADDR_BITS-1:0] instr_address;
		logic [23:0]          offset_field;
		logic                 absolute;
		logic                 link;
		logic [4:0]           bo;
		logic [4:0]           bi;
		logic [31:0]          cr_word;
		logic [REG_BITS-1:0]  write_value;
	} bru_req_t;

	typedef struct packed {
		logic                 taken;
		logic [ADDR_BITS-1:0] target;
		logic [REG_BITS-1:0]  link_now;
		logic [REG_BITS-1:0]  count_now;
	} bru_rsp_t;

	// next values of the architectural registers
	typedef struct packed {
		logic [REG_BITS-1:0] count_d;
		logic [REG_BITS-1:0] link_d;
	} bru_upd_t;

endpackage

[rtl/bru_resolve.sv]
// combinational branch resolution: condition and count tests, target, register updates
`timescale 1ns / 1ps

module bru_resolve (
	input  bru_pkg::bru_req_t        req,
	input  logic [bru_pkg::REG_BITS-1:0] count_cur,
	input  logic [bru_pkg::REG_BITS-1:0] link_cur,
	output bru_pkg::bru_rsp_t        rsp,
	output bru_pkg::bru_upd_t        upd
);
	import bru_pkg::*;

	logic                 cond_ok;
	logic                 cnt_ok;
	logic                 dec_en;
	logic                 is_branch;
	logic [REG_BITS-1:0]  count_dec;
	logic [ADDR_BITS-1:0] disp_li;
	logic [ADDR_BITS-1:0] disp_bd;
	logic [ADDR_BITS-1:0] target;
	logic                 taken;
	logic [REG_BITS-1:0]  count_nx;
	logic [REG_BITS-1:0]  link_nx;

	// bit 31-bi of the condition word is bit ~bi for a 5-bit index
	assign cond_ok = req.bo[4] | (req.cr_word[~req.bi] == req.bo[3]);

	assign count_dec = count_cur - REG_BITS'(1);
	assign dec_en    = ((req.command == CMD_BC) || (req.command == CMD_BCLR)) && !req.bo[2];
	assign cnt_ok    = req.bo[2] |
		(req.bo[1] ? (count_dec[31:0] == 32'd0) : (count_dec[31:0] != 32'd0));

	assign disp_li = {{(ADDR_BITS-26){req.offset_field[23]}}, req.offset_field, 2'b00};
	assign disp_bd = {{(ADDR_BITS-16){req.offset_field[13]}}, req.offset_field[13:0], 2'b00};

	always_comb begin
		is_branch = 1'b1;
		taken     = 1'b0;
		target    = '0;
		unique case (req.command)
			CMD_BX: begin
				taken  = 1'b1;
				target = req.absolute ? disp_li : req.instr_address + disp_li;
			end
			CMD_BC: begin
				taken  = cnt_ok & cond_ok;
				target = req.absolute ? disp_bd : req.instr_address + disp_bd;
			end
			CMD_BCCTR: begin
				taken  = cond_ok;
				target = count_cur[ADDR_BITS-1:0];
			end
			CMD_BCLR: begin
				taken  = cnt_ok & cond_ok;
				target = link_cur[ADDR_BITS-1:0];
			end
			default: begin
				is_branch = 1'b0;
			end
		endcase
	end

	always_comb begin
		count_nx = count_cur;
		if (dec_en) begin
			count_nx = count_dec;
		end else if (req.command == CMD_WCOUNT) begin
			count_nx = req.write_value;
		end
	end

	always_comb begin
		link_nx = link_cur;
		if (is_branch && req.link) begin
			link_nx = REG_BITS'(req.instr_address) + REG_BITS'(4);
		end else if (req.command == CMD_WLINK) begin
			link_nx = req.write_value;
		end
	end

	assign rsp.taken     = taken;
	assign rsp.target    = target;
	assign rsp.link_now  = link_nx;
	assign rsp.count_now = count_nx;
	assign upd.count_d   = count_nx;
	assign upd.link_d    = link_nx;

endmodule

[rtl/branch_resolution_unit_core.sv]
// top level of the branch resolution unit: request register, resolve logic, result register
`timescale 1ns / 1ps

// Branch resolution unit. Each request (bx, bcx, bcctrx, bclrx, or a direct
// load of count or link) gives exactly one result carrying taken, the 32-bit
// target and the count and link registers as they stand after the request.
// A request is latched into an input register, resolved by one pass of
// combinational logic (condition bit test, 64-bit count decrement with a
// low-word zero test, one 32-bit target add) and captured in the result
// register; one request is accepted every cycle while req_stall is low. The
// count and link registers update at the same edge the result is captured, so
// a following request already sees them. req_stall rises only when the input
// register is full and the result register is held by rsp_stall. No clearing
// pass: both registers reset to zero.
module branch_resolution_unit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bru_pkg::bru_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bru_pkg::bru_rsp_t rsp
);
	import bru_pkg::*;

	// input register stage
	logic     req_valid_s1;
	bru_req_t req_s1;

	// architectural state
	logic [REG_BITS-1:0] count_q;
	logic [REG_BITS-1:0] link_q;

	// resolve outputs
	bru_rsp_t rsp_d;
	bru_upd_t upd;

	logic out_free;
	logic advance;
	logic accept;

	// result register can take a new value when empty or being drained
	assign out_free  = !rsp_valid || !rsp_stall;
	assign advance   = req_valid_s1 && out_free;
	// stage 1 frees up when empty or moving into the result register
	assign req_stall = req_valid_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	bru_resolve u_resolve (
		.req       (req_s1),
		.count_cur (count_q),
		.link_cur  (link_q),
		.rsp       (rsp_d),
		.upd       (upd)
	);

	// count and link commit together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			link_q  <= '0;
		end else if (advance) begin
			count_q <= upd.count_d;
			link_q  <= upd.link_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_free) begin
			rsp_valid <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	// stall only ever comes from a full input stage
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> req_valid_s1)
		else $error("request stall without a held request");

	// the result carries the committed count and link
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (rsp.count_now == count_q) && (rsp.link_now == link_q))
		else $error("result registers differ from committed state");

	// a count load commits the written value
	a_count_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.command == CMD_WCOUNT) |=>
			(count_q == $past(req_s1.write_value)))
		else $error("count load lost");

	// non-branch commands never report a taken branch or a target
	a_nonbranch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.command != CMD_BX && req_s1.command != CMD_BC &&
			req_s1.command != CMD_BCCTR && req_s1.command != CMD_BCLR) |=>
			(!rsp.taken && rsp.target == '0))
		else $error("non-branch request produced a branch result");
`endif

endmodule

[tb/sv/branch_outcome_checker.sv]
// checker: predicts each branch outcome and compares it with the unit's result channel
`timescale 1ns / 1ps

module branch_outcome_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  bru_pkg::bru_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  bru_pkg::bru_rsp_t rsp,
	output int                error_count,
	output int                outstanding
);
	import bru_pkg::*;

	// bit positions inside the BO field
	localparam int BO_SKIP_COND  = 4;
	localparam int BO_COND_VALUE = 3;
	localparam int BO_SKIP_COUNT = 2;
	localparam int BO_WANT_ZERO  = 1;

	logic [REG_BITS-1:0] ctr_model;
	logic [REG_BITS-1:0] lr_model;
	bru_rsp_t            outcome_q[$];
	bru_rsp_t            fresh;
	bru_rsp_t            want;

	initial begin
		error_count = 0;
		outstanding = 0;
	end

	// resolves one request against the modeled count and link registers
	task automatic resolve_branch(input bru_req_t r, output bru_rsp_t o);
		logic [REG_BITS-1:0]  prior_link;
		logic [ADDR_BITS-1:0] disp;
		logic                 count_ok;
		logic                 cond_ok;
		logic                 is_branch;
		prior_link = lr_model;
		o = '0;
		is_branch = 1'b1;
		count_ok = 1'b1;
		cond_ok = r.bo[BO_SKIP_COND] || (r.cr_word[31 - r.bi] == r.bo[BO_COND_VALUE]);
		if (!r.bo[BO_SKIP_COUNT] && (r.command == CMD_BC || r.command == CMD_BCLR)) begin
			ctr_model = ctr_model - 64'd1;
			count_ok = r.bo[BO_WANT_ZERO] ? (ctr_model[31:0] == 32'd0)
			                              : (ctr_model[31:0] != 32'd0);
		end
		case (r.command)
			CMD_BX: begin
				disp = {{6{r.offset_field[23]}}, r.offset_field, 2'b00};
				o.target = r.absolute ? disp : r.instr_address + disp;
				o.taken = 1'b1;
			end
			CMD_BC: begin
				disp = {{16{r.offset_field[13]}}, r.offset_field[13:0], 2'b00};
				o.target = r.absolute ? disp : r.instr_address + disp;
				o.taken = count_ok && cond_ok;
			end
			CMD_BCCTR: begin
				o.target = ctr_model[ADDR_BITS-1:0];
				o.taken = cond_ok;
			end
			CMD_BCLR: begin
				o.target = prior_link[ADDR_BITS-1:0];
				o.taken = count_ok && cond_ok;
			end
			CMD_WCOUNT: begin
				ctr_model = r.write_value;
				is_branch = 1'b0;
			end
			CMD_WLINK: begin
				lr_model = r.write_value;
				is_branch = 1'b0;
			end
			default: begin
				is_branch = 1'b0;
			end
		endcase
		if (is_branch && r.link)
			lr_model = {32'd0, r.instr_address} + 64'd4;
		o.link_now = lr_model;
		o.count_now = ctr_model;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_model = '0;
			lr_model = '0;
			outcome_q.delete();
		end else begin
			if (req_valid && !req_stall) begin
				resolve_branch(req, fresh);
				outcome_q.push_back(fresh);
			end
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request waiting: taken %0d target %h",
						rsp.taken, rsp.target);
					error_count++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp.taken !== want.taken) begin
						$error("taken: expected %0d, actual %0d", want.taken, rsp.taken);
						error_count++;
					end
					if (rsp.target !== want.target) begin
						$error("target: expected %h, actual %h", want.target, rsp.target);
						error_count++;
					end
					if (rsp.link_now !== want.link_now) begin
						$error("link_now: expected %h, actual %h", want.link_now, rsp.link_now);
						error_count++;
					end
					if (rsp.count_now !== want.count_now) begin
						$error("count_now: expected %h, actual %h", want.count_now,
							rsp.count_now);
						error_count++;
					end
				end
			end
		end
		outstanding = outcome_q.size();
	end

endmodule

[tb/sv/tb_branch_resolution_unit_core.sv]
// testbench top: drives branch requests into the unit and gives the verdict
`timescale 1ns / 1ps

module tb_branch_resolution_unit_core;
	import bru_pkg::*;

	// command codes the unit leaves unused
	localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

	localparam int PHASES           = 4;
	localparam int RANDOM_PER_PHASE = 460;
	localparam int CYCLE_LIMIT      = 200000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	bru_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	bru_rsp_t rsp;

	int error_count;
	int outstanding;
	int cycle_count  = 0;
	int send_gap_pct = 0;
	int stall_pct    = 0;

	// idle and stall percentages per phase: none, sender only, receiver only, both
	int gap_by_phase[PHASES]   = '{0, 61, 0, 25};
	int stall_by_phase[PHASES] = '{0, 0, 61, 25};

	always #1 clk = ~clk;

	branch_resolution_unit_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	branch_outcome_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bru_req_t make_req(input logic [CMD_BITS-1:0] cmd,
		input logic [4:0] bo, input logic [4:0] bi, input logic [31:0] cr,
		input logic [31:0] addr, input logic [23:0] off, input logic aa,
		input logic lk, input logic [63:0] wv);
		bru_req_t r;
		r.command       = cmd;
		r.bo            = bo;
		r.bi            = bi;
		r.cr_word       = cr;
		r.instr_address = addr;
		r.offset_field  = off;
		r.absolute      = aa;
		r.link          = lk;
		r.write_value   = wv;
		return r;
	endfunction

	// mostly conditional branches, with enough small count loads that
	// the decrement keeps crossing zero
	function automatic bru_req_t random_req();
		bru_req_t r;
		int       pick;
		r.instr_address = $urandom;
		r.offset_field  = 24'($urandom);
		r.absolute      = 1'($urandom_range(1));
		r.link          = 1'($urandom_range(1));
		r.bo            = 5'($urandom);
		r.bi            = 5'($urandom);
		r.cr_word       = $urandom;
		r.write_value   = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 12)
			r.command = CMD_BX;
		else if (pick < 40)
			r.command = CMD_BC;
		else if (pick < 52)
			r.command = CMD_BCCTR;
		else if (pick < 72)
			r.command = CMD_BCLR;
		else if (pick < 84)
			r.command = CMD_WCOUNT;
		else if (pick < 96)
			r.command = CMD_WLINK;
		else if (pick < 98)
			r.command = CMD_SPARE_LO;
		else
			r.command = CMD_SPARE_HI;
		if (r.command == CMD_WCOUNT) begin
			case ($urandom_range(3))
				0: r.write_value = 64'($urandom_range(3));
				// low word near zero with a busy high word
				1: r.write_value = {$urandom, 32'd0} | 64'($urandom_range(2));
				default: ;
			endcase
		end
		// top-of-space addresses push the link value past 32 bits
		if ($urandom_range(15) == 0)
			r.instr_address = 32'hFFFF_FFFC | $urandom_range(3);
		return r;
	endfunction

	// one request: optional idle gap, then hold until accepted
	task automatic send_request(input bru_req_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// sender goes quiet until every predicted result has been seen
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bx: widest forward jump, backward wrap below zero, absolute most
		// negative with link from the top address, relative wrap at the top
		send_request(make_req(CMD_BX, 5'd0, 5'd0, 32'd0, 32'h0000_1000, 24'h7F_FFFF,
			1'b0, 1'b0, 64'd0));
		send_request(make_req(CMD_BX, 5'd0, 5'd0, 32'd0, 32'h0000_0000, 24'hFF_FFFF,
			1'b0, 1'b1, 64'd0));
		send_request(make_req(CMD_BX, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			24'h80_0000, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(make_req(CMD_BX, 5'd0, 5'd0, 32'd0, 32'hFFFF_FFF0, 24'h00_0004,
			1'b0, 1'b0, 64'd0));

		// bcx: decrement from zero wraps to all ones; upper LI bits ignored
		send_request(make_req(CMD_BC, 5'b10000, 5'd0, 32'd0, 32'h0000_2000, 24'hFF_C000,
			1'b0, 1'b0, 64'd0));
		// only the low word of the count is tested for zero
		send_request(make_req(CMD_WCOUNT, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'h0000_0001_0000_0001));
		send_request(make_req(CMD_BC, 5'b10010, 5'd0, 32'd0, 32'h0000_0100, 24'h00_2000,
			1'b0, 1'b0, 64'd0));
		send_request(make_req(CMD_BC, 5'b10000, 5'd0, 32'd0, 32'hFFFF_FFFC, 24'h00_1FFF,
			1'b1, 1'b1, 64'd0));
		// count reaches zero under a non-zero test: not taken
		send_request(make_req(CMD_WCOUNT, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'd1));
		send_request(make_req(CMD_BC, 5'b00000, 5'd0, 32'h7FFF_FFFF, 32'h0000_0400,
			24'h00_0010, 1'b0, 1'b0, 64'd0));
		// condition only: top cr bit matches, bottom cr bit mismatches
		send_request(make_req(CMD_BC, 5'b01100, 5'd0, 32'h8000_0000, 32'h0000_0800,
			24'h00_0020, 1'b0, 1'b0, 64'd0));
		send_request(make_req(CMD_BC, 5'b00100, 5'd31, 32'h0000_0001, 32'h0000_0800,
			24'h00_0020, 1'b0, 1'b0, 64'd0));

		// bcctrx: target from the low word of the count, no decrement whatever BO says
		send_request(make_req(CMD_WCOUNT, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(make_req(CMD_BCCTR, 5'b10000, 5'd0, 32'd0, 32'h0000_0040, 24'd0,
			1'b0, 1'b1, 64'd0));
		send_request(make_req(CMD_BCCTR, 5'b01010, 5'd5, 32'h0400_0000, 32'h0000_0080,
			24'd0, 1'b0, 1'b0, 64'd0));

		// bclrx: target is the link before this request's own link update
		send_request(make_req(CMD_WLINK, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'h1234_5678_9ABC_DEF3));
		send_request(make_req(CMD_BCLR, 5'b10100, 5'd0, 32'd0, 32'h0000_0500, 24'd0,
			1'b0, 1'b1, 64'd0));
		send_request(make_req(CMD_BCLR, 5'b00010, 5'd0, 32'd0, 32'h0000_0600, 24'd0,
			1'b0, 1'b0, 64'd0));

		// unused commands leave both registers alone, even with link set
		send_request(make_req(CMD_SPARE_LO, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			24'hFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(make_req(CMD_SPARE_HI, 5'd0, 5'd0, 32'd0, 32'h0000_0700, 24'd0,
			1'b0, 1'b1, 64'd0));

		// register extremes, then a bclrx that wraps the count
		send_request(make_req(CMD_WLINK, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(make_req(CMD_WCOUNT, 5'd0, 5'd0, 32'd0, 32'd0, 24'd0,
			1'b0, 1'b0, 64'd0));
		send_request(make_req(CMD_BCLR, 5'b00000, 5'd0, 32'd0, 32'h0000_0900, 24'd0,
			1'b0, 1'b0, 64'd0));

		// random traffic under each idling mix, fully drained between phases
		for (int phase = 0; phase < PHASES; phase++) begin
			send_gap_pct = gap_by_phase[phase];
			stall_pct = stall_by_phase[phase];
			repeat (RANDOM_PER_PHASE) send_request(random_req());
			hold_until_drained();
		end

		// let the two-stage pipe settle before the verdict
		stall_pct = 0;
		repeat (8) @(negedge clk);
		if (error_count == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
